>>> hdl/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types and codes for the terminal key sequence decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TYPE_W = 4;
    localparam int unsigned MOD_W  = 2;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned KEY_W  = TYPE_W + MOD_W + CHAR_W;
    localparam int unsigned OUT_W  = ((KEY_W + 7) / 8) * 8;

    // Key type codes
    localparam logic [TYPE_W-1:0] KT_NONE      = 4'd0;
    localparam logic [TYPE_W-1:0] KT_LEFT      = 4'd1;
    localparam logic [TYPE_W-1:0] KT_RIGHT     = 4'd2;
    localparam logic [TYPE_W-1:0] KT_UP        = 4'd3;
    localparam logic [TYPE_W-1:0] KT_DOWN      = 4'd4;
    localparam logic [TYPE_W-1:0] KT_HOME      = 4'd5;
    localparam logic [TYPE_W-1:0] KT_END       = 4'd6;
    localparam logic [TYPE_W-1:0] KT_BACKSPACE = 4'd7;
    localparam logic [TYPE_W-1:0] KT_RETURN    = 4'd8;
    localparam logic [TYPE_W-1:0] KT_TAB       = 4'd9;
    localparam logic [TYPE_W-1:0] KT_TEXT      = 4'd10;

    // Modifier bits
    localparam logic [MOD_W-1:0] MOD_NONE    = 2'b00;
    localparam logic [MOD_W-1:0] MOD_SHIFT   = 2'b01;
    localparam logic [MOD_W-1:0] MOD_CONTROL = 2'b10;
    localparam logic [MOD_W-1:0] MOD_BOTH    = 2'b11;

    // Byte codes
    localparam logic [BYTE_W-1:0] CH_ESC  = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_DEL  = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LBRK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_1    = 8'h31;
    localparam logic [BYTE_W-1:0] CH_2    = 8'h32;
    localparam logic [BYTE_W-1:0] CH_5    = 8'h35;
    localparam logic [BYTE_W-1:0] CH_6    = 8'h36;
    localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_B    = 8'h42;
    localparam logic [BYTE_W-1:0] CH_C    = 8'h43;
    localparam logic [BYTE_W-1:0] CH_D    = 8'h44;
    localparam logic [BYTE_W-1:0] CH_F    = 8'h46;
    localparam logic [BYTE_W-1:0] CH_H    = 8'h48;
    localparam logic [BYTE_W-1:0] CH_CTRL_LO  = 8'h01;
    localparam logic [BYTE_W-1:0] CH_CTRL_HI  = 8'h1A;
    localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7E;
    localparam logic [BYTE_W-1:0] CTRL_OFFSET = 8'h40;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic [MOD_W-1:0]  key_modifier;
        logic [TYPE_W-1:0] key_type;
    } t_key;

    typedef struct packed {
        logic emit;
        t_key key;
    } t_dec_res;

    function automatic logic [TYPE_W-1:0] letter_key(input logic [BYTE_W-1:0] b);
        logic [TYPE_W-1:0] kt;
        case (b)
            CH_D:    kt = KT_LEFT;
            CH_C:    kt = KT_RIGHT;
            CH_A:    kt = KT_UP;
            CH_B:    kt = KT_DOWN;
            CH_H:    kt = KT_HOME;
            CH_F:    kt = KT_END;
            default: kt = KT_NONE;
        endcase
        return kt;
    endfunction

endpackage

>>> hdl/terminal_key_sequence_decoder.sv
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Decodes raw terminal bytes into keypresses, including ESC [ sequences.
// ----------------------------------------------------------------------------
// One received byte per slave beat. Plain bytes decode at once: DEL gives
// backspace, LF return, TAB tab, 0x01..0x1A control plus letter, printables
// text, anything else a "none" key. ESC opens a sequence (ESC [ x or
// ESC [ 1 ; m x with m = 2 shift, 5 control, 6 both); bytes inside a sequence
// give no beat until it completes or breaks off, and a broken sequence gives
// one "none" key. Each byte passes through an input register, the decode
// logic and the result register; one byte per clock is sustained unless
// m_tready stalls. The only stall comes from m_tready: with the result
// register full and not taken, a byte that would produce a key waits in the
// input register.
module terminal_key_sequence_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tksd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tksd_pkg::OUT_W-1:0]    m_tdata    // [3:0] key_type,
                                                     // [5:4] key_modifier,
                                                     // [12:6] text_char,
                                                     // [15:13] zero
);
    import tksd_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_dec_res          dec_res;
    logic              out_room;
    logic              adv;

    // byte in the input register leaves when it either makes no key or
    // the result register can take its key
    assign adv      = r_in_valid && (!dec_res.emit || out_room);
    assign s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata;
        end
    end

    tksd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .o_res   (dec_res)
    );

    tksd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv && dec_res.emit),
        .i_key    (dec_res.key),
        .o_room   (out_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> hdl/tksd_decode.sv
// ----------------------------------------------------------------------------
// tksd_decode
// Parser state and per-byte decode into an optional key result.
// ----------------------------------------------------------------------------
module tksd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,   // consume i_byte this cycle
    input  logic [tksd_pkg::BYTE_W-1:0]   i_byte,
    output tksd_pkg::t_dec_res            o_res
);
    import tksd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_CSI  = 3'd2,
        PH_ONE  = 3'd3,
        PH_SEMI = 3'd4,
        PH_MOD  = 3'd5
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [MOD_W-1:0]  r_mod,   n_mod;
    t_dec_res          res;

    always_comb begin
        n_phase  = PH_IDLE;
        n_mod    = MOD_NONE;
        res.emit = 1'b1;
        res.key  = '{text_char: '0, key_modifier: MOD_NONE, key_type: KT_NONE};
        case (r_phase)
            PH_ESC: begin
                if (i_byte == CH_LBRK) begin
                    n_phase  = PH_CSI;
                    res.emit = 1'b0;
                end
            end
            PH_CSI: begin
                if (i_byte == CH_1) begin
                    n_phase  = PH_ONE;
                    res.emit = 1'b0;
                end else begin
                    res.key.key_type = letter_key(i_byte);
                end
            end
            PH_ONE: begin
                if (i_byte == CH_SEMI) begin
                    n_phase  = PH_SEMI;
                    res.emit = 1'b0;
                end
            end
            PH_SEMI: begin
                if (i_byte == CH_2 || i_byte == CH_5 || i_byte == CH_6) begin
                    n_phase  = PH_MOD;
                    res.emit = 1'b0;
                    n_mod    = (i_byte == CH_2) ? MOD_SHIFT :
                               (i_byte == CH_5) ? MOD_CONTROL : MOD_BOTH;
                end
            end
            PH_MOD: begin
                res.key.key_type     = letter_key(i_byte);
                res.key.key_modifier = r_mod;
            end
            default: begin
                // idle
                if (i_byte == CH_ESC) begin
                    n_phase  = PH_ESC;
                    res.emit = 1'b0;
                end else if (i_byte == CH_DEL) begin
                    res.key.key_type = KT_BACKSPACE;
                end else if (i_byte == CH_LF) begin
                    res.key.key_type = KT_RETURN;
                end else if (i_byte == CH_TAB) begin
                    res.key.key_type = KT_TAB;
                end else if (i_byte inside {[CH_CTRL_LO:CH_CTRL_HI]}) begin
                    res.key.key_type     = KT_TEXT;
                    res.key.key_modifier = MOD_CONTROL;
                    res.key.text_char    = CHAR_W'(i_byte + CTRL_OFFSET);
                end else if (i_byte inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
                    res.key.key_type  = KT_TEXT;
                    res.key.text_char = i_byte[CHAR_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mod   <= MOD_NONE;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_mod   <= n_mod;
        end
    end

    assign o_res = res;

endmodule

>>> hdl/tksd_out_reg.sv
// ----------------------------------------------------------------------------
// tksd_out_reg
// Result register on the master side; holds a key beat until taken.
// ----------------------------------------------------------------------------
module tksd_out_reg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  tksd_pkg::t_key               i_key,
    output logic                         o_room,   // a load this cycle is safe
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tksd_pkg::OUT_W-1:0]   m_tdata
);
    import tksd_pkg::*;

    logic r_valid;
    t_key r_key;

    assign o_room = !r_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= i_key;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = OUT_W'(r_key);

endmodule

>>> hdl/tksd_checker.sv
// ----------------------------------------------------------------------------
// tksd_port_checker
// Port-level checks for the terminal key sequence decoder.
// ----------------------------------------------------------------------------
module tksd_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [tksd_pkg::BYTE_W-1:0]   s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tksd_pkg::OUT_W-1:0]    m_tdata
);
    import tksd_pkg::*;

    t_key key;
    assign key = m_tdata[KEY_W-1:0];

    // held master beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("master beat changed while stalled");

    // offered slave beat stays put until taken
    a_s_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("slave beat changed while stalled");

    // reset leaves nothing pending and opens the slave side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("state after reset wrong");

    // text_char nonzero exactly for text keys
    a_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> ((key.key_type == KT_TEXT) == (key.text_char != '0)))
        else $error("text_char inconsistent with key_type");

    // no key codes beyond text, padding bits clear
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (key.key_type <= KT_TEXT) && (m_tdata[OUT_W-1:KEY_W] == '0))
        else $error("invalid key beat");

endmodule

bind terminal_key_sequence_decoder tksd_port_checker u_tksd_port_checker (.*);

>>> sim/tksd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tksd_checker
// Watches both streams of the key decoder, predicts keys and compares them.
// ----------------------------------------------------------------------------
module tksd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [tksd_pkg::BYTE_W-1:0]    i_s_tdata,   // [7:0] rx_byte
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [tksd_pkg::OUT_W-1:0]     i_m_tdata,   // [3:0] key_type,
                                                        // [5:4] key_modifier,
                                                        // [12:6] text_char,
                                                        // [15:13] zero
    input  logic                           i_done,
    output int                             o_err_cnt,
    output int                             o_pending,
    output int                             o_keys_checked,
    output logic [15:0]                    o_types_seen,
    output logic [3:0]                     o_mods_seen
);
    import tksd_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ESC,
        SEQ_CSI,
        SEQ_ONE,
        SEQ_SEMI,
        SEQ_MOD
    } t_seq_phase;

    t_seq_phase        seq_phase;
    logic [MOD_W-1:0]  held_mod;
    t_key              key_queue [$];
    t_dec_res          pred;
    t_key              want;
    t_key              got;
    logic              done_seen;

    task automatic report(input string what, input int got_v, input int want_v);
        o_err_cnt++;
        if (o_err_cnt <= PRINT_CAP)
            $display("tksd_checker: %0t %s: got %0d, expected %0d", $realtime, what,
                     got_v, want_v);
    endtask

    // Final byte of a cursor sequence; unknown letters map to none.
    function automatic logic [TYPE_W-1:0] arrow_key(input logic [BYTE_W-1:0] b);
        if (b == CH_A) return KT_UP;
        if (b == CH_B) return KT_DOWN;
        if (b == CH_C) return KT_RIGHT;
        if (b == CH_D) return KT_LEFT;
        if (b == CH_F) return KT_END;
        if (b == CH_H) return KT_HOME;
        return KT_NONE;
    endfunction

    // Advances the sequence parser by one byte; emit set when a key completes.
    function automatic t_dec_res decode_byte(input logic [BYTE_W-1:0] b);
        t_dec_res r;
        logic [BYTE_W-1:0] ctrl_char;
        r = '0;
        r.emit = 1'b1;
        ctrl_char = b + CTRL_OFFSET;
        case (seq_phase)
            SEQ_ESC: begin
                if (b == CH_LBRK) begin
                    seq_phase = SEQ_CSI;
                    r.emit = 1'b0;
                end
            end
            SEQ_CSI: begin
                if (b == CH_1) begin
                    seq_phase = SEQ_ONE;
                    r.emit = 1'b0;
                end else begin
                    r.key.key_type = arrow_key(b);
                end
            end
            SEQ_ONE: begin
                if (b == CH_SEMI) begin
                    seq_phase = SEQ_SEMI;
                    r.emit = 1'b0;
                end
            end
            SEQ_SEMI: begin
                r.emit = 1'b0;
                seq_phase = SEQ_MOD;
                if (b == CH_2)
                    held_mod = MOD_SHIFT;
                else if (b == CH_5)
                    held_mod = MOD_CONTROL;
                else if (b == CH_6)
                    held_mod = MOD_BOTH;
                else
                    r.emit = 1'b1;   // bad modifier digit: none, no modifier
            end
            SEQ_MOD: begin
                // modifier is reported even when the letter is unknown
                r.key.key_type     = arrow_key(b);
                r.key.key_modifier = held_mod;
            end
            default: begin
                if (b == CH_ESC) begin
                    seq_phase = SEQ_ESC;
                    held_mod  = MOD_NONE;
                    r.emit    = 1'b0;
                end else if (b == CH_DEL) begin
                    r.key.key_type = KT_BACKSPACE;
                end else if (b == CH_LF) begin
                    r.key.key_type = KT_RETURN;
                end else if (b == CH_TAB) begin
                    r.key.key_type = KT_TAB;
                end else if (b >= CH_CTRL_LO && b <= CH_CTRL_HI) begin
                    r.key.key_type     = KT_TEXT;
                    r.key.key_modifier = MOD_CONTROL;
                    r.key.text_char    = ctrl_char[CHAR_W-1:0];
                end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
                    r.key.key_type  = KT_TEXT;
                    r.key.text_char = b[CHAR_W-1:0];
                end
            end
        endcase
        if (r.emit) begin
            seq_phase = SEQ_IDLE;
            held_mod  = MOD_NONE;
        end
        return r;
    endfunction

    initial begin
        o_err_cnt      = 0;
        o_pending      = 0;
        o_keys_checked = 0;
        o_types_seen   = '0;
        o_mods_seen    = '0;
        seq_phase      = SEQ_IDLE;
        held_mod       = MOD_NONE;
        done_seen      = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_queue.delete();
            seq_phase = SEQ_IDLE;
            held_mod  = MOD_NONE;
        end else begin
            // output side first: a key can never come from this cycle's byte
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[KEY_W-1:0];
                if (key_queue.size() == 0) begin
                    report("key with none pending", got.key_type, -1);
                end else begin
                    want = key_queue.pop_front();
                    o_keys_checked++;
                    if (got.key_type !== want.key_type)
                        report("key_type", got.key_type, want.key_type);
                    if (got.key_modifier !== want.key_modifier)
                        report("key_modifier", got.key_modifier, want.key_modifier);
                    if (got.text_char !== want.text_char)
                        report("text_char", got.text_char, want.text_char);
                    if (i_m_tdata[OUT_W-1:KEY_W] !== '0)
                        report("pad bits", i_m_tdata[OUT_W-1:KEY_W], 0);
                    o_types_seen[want.key_type]    <= 1'b1;
                    o_mods_seen[want.key_modifier] <= 1'b1;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pred = decode_byte(i_s_tdata);
                if (pred.emit)
                    key_queue.push_back(pred.key);
            end
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                foreach (key_queue[k])
                    report("key never delivered", -1, key_queue[k].key_type);
            end
        end
        o_pending <= key_queue.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the terminal key sequence decoder.
// ----------------------------------------------------------------------------
// Feeds raw terminal bytes: a directed opener (range edges, control keys,
// every broken-sequence case, a modified sequence with an unknown letter),
// then random traffic that is mostly well-formed ESC sequences with random
// letters and modifiers, mixed with noise bytes and cut-off sequences.
// Both sides idle in random bursts; once the sink holds off long enough for
// the decoder to back up and drop s_tready. tksd_checker does all prediction
// and comparison; this module only drives and reports.
module tb_top;
    import tksd_pkg::*;

    localparam int N_BYTES        = 750;
    localparam int SEGMENT        = 60;    // bytes per idling mode
    localparam int QUIET_TAIL     = 120;   // last bytes run without idling
    localparam int HOLD_CYCLES    = 300;   // long sink hold-off
    localparam int HOLD_AT        = 200;   // byte count that triggers it
    localparam int DRAIN_CYCLES   = 8;     // slack once nothing is pending
    localparam int WATCHDOG_LIMIT = 2000;  // beat-free cycles before giving up

    localparam logic [1:0] IDLE_OFF    = 2'd0;
    localparam logic [1:0] IDLE_SPARSE = 2'd1;
    localparam logic [1:0] IDLE_DENSE  = 2'd2;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;    // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;    // [3:0] key_type, [5:4] key_modifier,
                                      // [12:6] text_char, [15:13] zero
    logic                 chk_done;
    int                   err_cnt;
    int                   pending;
    int                   keys_checked;
    logic [15:0]          types_seen;
    logic [3:0]           mods_seen;

    logic [1:0]           idle_mode;
    logic                 hold_req;
    logic                 hold_active;
    logic                 hold_done;
    int                   bytes_sent;

    logic [BYTE_W-1:0]    opener [$];

    // ------------------------------------------------------------------------
    // Clock: 4 ns period
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    terminal_key_sequence_decoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tksd_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_done         (chk_done),
        .o_err_cnt      (err_cnt),
        .o_pending      (pending),
        .o_keys_checked (keys_checked),
        .o_types_seen   (types_seen),
        .o_mods_seen    (mods_seen)
    );

    // ------------------------------------------------------------------------
    // Watchdog: any beat on either side resets the count
    // ------------------------------------------------------------------------
    int stall_cnt;
    initial stall_cnt = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("tb_top: no beat for %0d cycles, %0d keys still pending",
                         WATCHDOG_LIMIT, pending);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink: random stall bursts, plus the one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        m_tready    = 1'b0;
        hold_active = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                m_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                // long enough that the decoder fills and stalls its input
                m_tready   <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end else if (idle_mode != IDLE_OFF &&
                         $urandom_range(0, (idle_mode == IDLE_DENSE) ? 3 : 15) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------
    // One slave beat; an optional idle burst goes in front of it. During the
    // hold-off the source keeps offering so the decoder backs up.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (!hold_active && idle_mode != IDLE_OFF &&
            $urandom_range(0, (idle_mode == IDLE_DENSE) ? 2 : 12) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        bytes_sent++;
        if (bytes_sent == HOLD_AT)
            hold_req = 1'b1;
    endtask

    // Mostly a real cursor letter, now and then any byte at all.
    function automatic logic [BYTE_W-1:0] pick_letter();
        case ($urandom_range(0, 7))
            0:       return CH_A;
            1:       return CH_B;
            2:       return CH_C;
            3:       return CH_D;
            4:       return CH_F;
            5:       return CH_H;
            6:       return CH_D;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_mod_digit();
        case ($urandom_range(0, 2))
            0:       return CH_2;
            1:       return CH_5;
            default: return CH_6;
        endcase
    endfunction

    initial begin
        logic [BYTE_W-1:0] csi_mod [5];
        int                cut;
        int                next_mode_at;

        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        chk_done  = 1'b0;
        hold_req  = 1'b0;
        idle_mode = IDLE_SPARSE;
        bytes_sent = 0;

        // Directed opener
        opener = '{
            8'h00, 8'hFF, CH_DEL, CH_LF, CH_TAB,     // edges and named keys
            CH_CTRL_LO, CH_CTRL_HI,                   // control-letter range ends
            CH_PRINT_LO, CH_PRINT_HI, 8'h1C, 8'h80,   // printable ends, dead bytes
            CH_ESC, 8'h78,                            // ESC then not '['
            CH_ESC, CH_LBRK, CH_D,                    // plain cursor key
            CH_ESC, CH_LBRK, CH_1, 8'h78,             // ESC[1 then not ';'
            CH_ESC, CH_LBRK, CH_1, CH_SEMI, 8'h39,    // bad modifier digit
            CH_ESC, CH_LBRK, CH_1, CH_SEMI, CH_6, 8'h5A  // both mods, unknown letter
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (opener[k])
            send_byte(opener[k]);

        // Random traffic
        next_mode_at = bytes_sent;
        while (bytes_sent < N_BYTES) begin
            if (bytes_sent >= N_BYTES - QUIET_TAIL) begin
                idle_mode = IDLE_OFF;
            end else if (bytes_sent >= next_mode_at) begin
                idle_mode    = 2'($urandom_range(0, 2));
                next_mode_at = bytes_sent + SEGMENT;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    send_byte(CH_ESC);
                    send_byte(CH_LBRK);
                    send_byte(pick_letter());
                end
                3, 4, 5: begin
                    send_byte(CH_ESC);
                    send_byte(CH_LBRK);
                    send_byte(CH_1);
                    send_byte(CH_SEMI);
                    send_byte(pick_mod_digit());
                    send_byte(pick_letter());
                end
                6: begin
                    // sequence cut short, then an arbitrary byte
                    csi_mod = '{CH_ESC, CH_LBRK, CH_1, CH_SEMI, pick_mod_digit()};
                    cut = $urandom_range(1, 4);
                    for (int k = 0; k < cut; k++)
                        send_byte(csi_mod[k]);
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end
                default: begin
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end
            endcase
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;

        // Drain: watchdog covers a decoder that never delivers
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        chk_done = 1'b1;
        repeat (2) @(posedge i_clk);

        $display("tb_top: %0d bytes in, %0d keys checked, %0d-cycle sink hold-off",
                 bytes_sent, keys_checked, HOLD_CYCLES);
        $display("tb_top: key types seen %b, modifier values seen %b, %0d mismatches",
                 types_seen[10:0], mods_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tksd_pkg.sv
hdl/tksd_decode.sv
hdl/tksd_out_reg.sv
hdl/terminal_key_sequence_decoder.sv
hdl/tksd_checker.sv
sim/tksd_checker.sv
sim/tb_top.sv
